[src/assert_macros.svh]
// Assertion macros used by the checker file.
// Each expects clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PRP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PRP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/prp_pkg.sv]
// Package for the page replacement tracker: request and status types,
// register indexes, field widths. No dependencies.
`timescale 1ns / 1ps

package prp_pkg;

  localparam int PAGE_W  = 10;
  localparam int OFF_W   = 19;
  localparam int CNT_W   = 5;
  localparam int FRAME_W = 4;
  localparam int CTR_W   = 16;
  localparam int POL_W   = 2;
  localparam int FC_W    = 5;
  localparam int DISK_W  = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] MAX_ALLOC = 5'd16;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_LIMIT  = 2'd3;

  localparam logic [POL_W-1:0] POL_FIFO   = 2'd0;
  localparam logic [POL_W-1:0] POL_SECOND = 2'd1;
  localparam logic [POL_W-1:0] POL_LRU    = 2'd2;

  localparam logic [CTR_W-1:0]  RST_CLEAN = 16'd16;
  localparam logic [FC_W-1:0]   RST_FC    = 5'd16;
  localparam logic [DISK_W-1:0] RST_DISK  = 10'd1007;

  typedef enum logic [0:0] {CMD_ACCESS, CMD_ALLOC} cmd_kind_t;

  typedef enum logic [2:0] {
    ST_HIT, ST_FAULT, ST_NO_PAGE, ST_ALLOC_MEM, ST_ALLOC_DISK, ST_NO_SPACE
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ALLOC, B_LOOKUP, B_ROTATE, B_SCAN, B_EVICT
  } back_state_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PAGE_W-1:0] page;
    logic [OFF_W-1:0]  offset;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    sat_inc = (v == {CTR_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

[src/page_replacement_policy.sv]
// Top level of the page replacement tracker: front end, command queue,
// back end. Uses prp_pkg, prp_front, prp_cmdq, prp_back.
//
//  channel  | ports                         | handshake
//  request  | in_*                          | start, accepted when busy low
//  result   | out_*                         | out_valid with each result
//  config   | cfg_we, cfg_index, cfg_wdata  | write on cfg_we
//
// Allocation: the request is dequeued, then one result per cycle per page.
// Access: dequeue and lookup on a hit, a fault into a free frame or an
//   unknown page; a fifo eviction adds the evict step, after a rotation of
//   referenced heads (second chance) or a scan of every resident frame (lru),
//   steps run by the sequencer in the back end.
// The queue holds two requests; busy rises when it is full.
// Reset is synchronous, no clearing pass; results cannot be held off.
`timescale 1ns / 1ps

module page_replacement_policy #(
  parameter int MAX_FRAMES  = 16,
  parameter int MAX_PAGES   = 1023,
  parameter int OFFSET_BITS = 19
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_req_type,
  input  logic [prp_pkg::PAGE_W-1:0]     in_page_number,
  input  logic [prp_pkg::OFF_W-1:0]      in_offset,
  input  logic [prp_pkg::CNT_W-1:0]      in_page_count,
  input  logic                           cfg_we,
  input  logic [prp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prp_pkg::CTR_W-1:0]      cfg_wdata,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [prp_pkg::PAGE_W-1:0]     out_page_number_res,
  output logic [prp_pkg::FRAME_W-1:0]    out_frame_index,
  output logic [prp_pkg::OFF_W-1:0]      out_phys_offset,
  output logic                           out_evicted_valid,
  output logic [prp_pkg::PAGE_W-1:0]     out_evicted_page,
  output logic [prp_pkg::CTR_W-1:0]      out_hit_count,
  output logic [prp_pkg::CTR_W-1:0]      out_miss_count,
  output logic                           out_last
);
  import prp_pkg::*;

  q_stat_t q_stat;
  cmd_t    f_cmd, q_head;
  logic    f_push, b_pop;

  prp_front u_front (
    .start, .in_req_type, .in_page_number, .in_offset, .in_page_count,
    .q_stat, .busy, .push(f_push), .cmd(f_cmd)
  );

  prp_cmdq #(.DEPTH(CMDQ_DEPTH)) u_cmdq (
    .clk, .rst_n, .push(f_push), .push_cmd(f_cmd), .pop(b_pop),
    .head(q_head), .stat(q_stat)
  );

  prp_back #(
    .MAX_FRAMES(MAX_FRAMES), .MAX_PAGES(MAX_PAGES), .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .q_stat, .q_cmd(q_head), .pop(b_pop),
    .out_valid, .out_status, .out_page_number_res, .out_frame_index,
    .out_phys_offset, .out_evicted_valid, .out_evicted_page,
    .out_hit_count, .out_miss_count, .out_last
  );

endmodule

[src/prp_front.sv]
// Front end: takes requests, clamps the page count, drops empty
// allocations and hands commands to the queue. Uses prp_pkg.
`timescale 1ns / 1ps

module prp_front (
  input  logic                     start,
  input  logic                     in_req_type,
  input  logic [prp_pkg::PAGE_W-1:0] in_page_number,
  input  logic [prp_pkg::OFF_W-1:0]  in_offset,
  input  logic [prp_pkg::CNT_W-1:0]  in_page_count,
  input  prp_pkg::q_stat_t         q_stat,
  output logic                     busy,
  output logic                     push,
  output prp_pkg::cmd_t            cmd
);
  import prp_pkg::*;

  logic [CNT_W-1:0] cnt;

  always_comb begin
    cnt = (in_page_count > MAX_ALLOC) ? MAX_ALLOC : in_page_count;
    cmd.kind   = in_req_type ? CMD_ALLOC : CMD_ACCESS;
    cmd.page   = in_page_number;
    cmd.offset = in_offset;
    cmd.count  = cnt;
    busy = q_stat.full;
    // an allocation of no pages gives no result at all
    push = start && !q_stat.full && (!in_req_type || (cnt != '0));
  end

endmodule

[src/prp_cmdq.sv]
// Short command queue between front and back end.
// Uses prp_pkg for the command type.
`timescale 1ns / 1ps

module prp_cmdq #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  prp_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output prp_pkg::cmd_t    head,
  output prp_pkg::q_stat_t stat
);
  import prp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  always_comb begin
    stat.full  = (cnt_r == CW'(DEPTH));
    stat.empty = (cnt_r == '0);
    head = mem_r[rd_r];
    do_push = push && !stat.full;
    do_pop  = pop && !stat.empty;
    wr_nxt = wr_r;
    rd_nxt = rd_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) mem_r[wr_r] <= push_cmd;
  end

endmodule

[src/prp_back.sv]
// Back end: resident queue, configuration registers and the sequencer
// that serves hits, faults, victim choice and allocations. Uses prp_pkg.
`timescale 1ns / 1ps

module prp_back #(
  parameter int MAX_FRAMES  = 16,
  parameter int MAX_PAGES   = 1023,
  parameter int OFFSET_BITS = 19
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [prp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prp_pkg::CTR_W-1:0]      cfg_wdata,
  input  prp_pkg::q_stat_t               q_stat,
  input  prp_pkg::cmd_t                  q_cmd,
  output logic                           pop,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [prp_pkg::PAGE_W-1:0]     out_page_number_res,
  output logic [prp_pkg::FRAME_W-1:0]    out_frame_index,
  output logic [prp_pkg::OFF_W-1:0]      out_phys_offset,
  output logic                           out_evicted_valid,
  output logic [prp_pkg::PAGE_W-1:0]     out_evicted_page,
  output logic [prp_pkg::CTR_W-1:0]      out_hit_count,
  output logic [prp_pkg::CTR_W-1:0]      out_miss_count,
  output logic                           out_last
);
  import prp_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RC_W  = $clog2(MAX_FRAMES + 1);
  localparam int AP_W  = $clog2(MAX_PAGES + 1);
  localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((64'd1 << OFFSET_BITS) - 64'd1);

  // resident queue
  logic [PAGE_W-1:0] q_page_r  [MAX_FRAMES], q_page_nxt  [MAX_FRAMES];
  logic              q_ref_r   [MAX_FRAMES], q_ref_nxt   [MAX_FRAMES];
  logic [CTR_W-1:0]  q_age_r   [MAX_FRAMES], q_age_nxt   [MAX_FRAMES];
  logic [IDX_W-1:0]  q_frame_r [MAX_FRAMES], q_frame_nxt [MAX_FRAMES];

  logic [RC_W-1:0]   rc_r, rc_nxt;
  logic [AP_W-1:0]   alloc_r, alloc_nxt;
  logic [DISK_W-1:0] disk_r, disk_nxt;
  logic [CTR_W-1:0]  asc_r, asc_nxt, hits_r, hits_nxt, misses_r, misses_nxt;

  logic [POL_W-1:0]  policy_r;
  logic [CTR_W-1:0]  clean_r;
  logic [FC_W-1:0]   fc_r;
  logic [DISK_W-1:0] disk_lim_r;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt, best_r, best_nxt;
  logic [CTR_W-1:0]  best_age_r, best_age_nxt;

  logic              ov_r, ov_nxt, ol_r, ol_nxt, oev_r, oev_nxt;
  status_t           ost_r, ost_nxt;
  logic [PAGE_W-1:0] opg_r, opg_nxt, oep_r, oep_nxt;
  logic [FRAME_W-1:0] ofr_r, ofr_nxt;
  logic [OFF_W-1:0]  oof_r, oof_nxt;
  logic [CTR_W-1:0]  oh_r, om_r;

  logic [RC_W-1:0]   lim;
  logic              free_frame;
  logic              hit;
  logic [IDX_W-1:0]  pos, last_idx, push_idx;
  logic              clean_now;
  logic [CTR_W-1:0]  asc_base;

  always_comb begin
    if (fc_r == '0)                    lim = RC_W'(1);
    else if (32'(fc_r) > MAX_FRAMES)   lim = RC_W'(MAX_FRAMES);
    else                               lim = RC_W'(fc_r);
    free_frame = (rc_r < lim);
    push_idx = IDX_W'(rc_r);
    last_idx = IDX_W'(rc_r - 1'b1);
    hit = 1'b0;
    pos = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if ((RC_W'(i) < rc_r) && (q_page_r[i] == cmd_r.page)) begin
        hit = 1'b1;
        pos = IDX_W'(i);
      end
    end
    clean_now = (asc_r >= clean_r);
    asc_base  = clean_now ? '0 : asc_r;
  end

  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      q_page_nxt[i]  = q_page_r[i];
      q_ref_nxt[i]   = q_ref_r[i];
      q_age_nxt[i]   = q_age_r[i];
      q_frame_nxt[i] = q_frame_r[i];
    end
    rc_nxt = rc_r;  alloc_nxt = alloc_r;  disk_nxt = disk_r;
    asc_nxt = asc_r;  hits_nxt = hits_r;  misses_nxt = misses_r;
    state_nxt = state_r;  cmd_nxt = cmd_r;  left_nxt = left_r;
    idx_nxt = idx_r;  best_nxt = best_r;  best_age_nxt = best_age_r;
    pop = 1'b0;
    ov_nxt = 1'b0;  ol_nxt = 1'b0;  ost_nxt = ST_HIT;
    opg_nxt = '0;  ofr_nxt = '0;  oof_nxt = '0;  oev_nxt = 1'b0;  oep_nxt = '0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          cmd_nxt = q_cmd;
          left_nxt = q_cmd.count;
          state_nxt = (q_cmd.kind == CMD_ALLOC) ? B_ALLOC : B_LOOKUP;
        end
      end

      B_ALLOC: begin
        ov_nxt = 1'b1;
        left_nxt = left_r - 1'b1;
        ol_nxt = (left_r == CNT_W'(1));
        if (32'(alloc_r) >= MAX_PAGES) begin
          ost_nxt = ST_NO_SPACE;
          ol_nxt = 1'b1;
        end else if (free_frame) begin
          alloc_nxt = alloc_r + 1'b1;
          q_page_nxt[push_idx]  = PAGE_W'(alloc_r + 1'b1);
          q_ref_nxt[push_idx]   = 1'b0;
          q_age_nxt[push_idx]   = '0;
          q_frame_nxt[push_idx] = push_idx;
          rc_nxt = rc_r + 1'b1;
          ost_nxt = ST_ALLOC_MEM;
          opg_nxt = PAGE_W'(alloc_r + 1'b1);
          ofr_nxt = FRAME_W'(push_idx);
        end else if (disk_r < disk_lim_r) begin
          disk_nxt = disk_r + 1'b1;
          alloc_nxt = alloc_r + 1'b1;
          ost_nxt = ST_ALLOC_DISK;
          opg_nxt = PAGE_W'(alloc_r + 1'b1);
        end else begin
          ost_nxt = ST_NO_SPACE;
          ol_nxt = 1'b1;
        end
        if (ol_nxt) state_nxt = B_IDLE;
      end

      B_LOOKUP: begin
        if (clean_now) begin
          for (int i = 0; i < MAX_FRAMES; i++) q_ref_nxt[i] = 1'b0;
        end
        asc_nxt = asc_base;
        state_nxt = B_IDLE;
        opg_nxt = cmd_r.page;
        if (hit) begin
          q_ref_nxt[pos] = 1'b1;
          hits_nxt = sat_inc(hits_r);
          asc_nxt = sat_inc(asc_base);
          for (int i = 0; i < MAX_FRAMES; i++)
            if (RC_W'(i) < rc_r) q_age_nxt[i] = sat_inc(q_age_r[i]);
          q_age_nxt[pos] = '0;
          ov_nxt = 1'b1;  ol_nxt = 1'b1;  ost_nxt = ST_HIT;
          ofr_nxt = FRAME_W'(q_frame_r[pos]);
          oof_nxt = cmd_r.offset & OFF_MASK;
        end else begin
          misses_nxt = sat_inc(misses_r);
          if ((cmd_r.page == '0) || (32'(cmd_r.page) > 32'(alloc_r))) begin
            ov_nxt = 1'b1;  ol_nxt = 1'b1;  ost_nxt = ST_NO_PAGE;
          end else if (free_frame) begin
            if (disk_r != '0) disk_nxt = disk_r - 1'b1;
            for (int i = 0; i < MAX_FRAMES; i++)
              if (RC_W'(i) < rc_r) q_age_nxt[i] = sat_inc(q_age_r[i]);
            q_page_nxt[push_idx]  = cmd_r.page;
            q_ref_nxt[push_idx]   = 1'b1;
            q_age_nxt[push_idx]   = '0;
            q_frame_nxt[push_idx] = push_idx;
            rc_nxt = rc_r + 1'b1;
            asc_nxt = sat_inc(asc_base);
            ov_nxt = 1'b1;  ol_nxt = 1'b1;  ost_nxt = ST_FAULT;
            ofr_nxt = FRAME_W'(push_idx);
            oof_nxt = cmd_r.offset & OFF_MASK;
          end else begin
            best_nxt = '0;
            best_age_nxt = '0;
            idx_nxt = '0;
            priority case (policy_r)
              POL_SECOND: state_nxt = B_ROTATE;
              POL_LRU:    state_nxt = B_SCAN;
              default:    state_nxt = B_EVICT;
            endcase
          end
        end
      end

      B_ROTATE: begin
        // referenced head goes to the tail with its bit cleared
        if (q_ref_r[0]) begin
          for (int i = 0; i < MAX_FRAMES - 1; i++) begin
            if (RC_W'(i + 1) < rc_r) begin
              q_page_nxt[i]  = q_page_r[i + 1];
              q_ref_nxt[i]   = q_ref_r[i + 1];
              q_age_nxt[i]   = q_age_r[i + 1];
              q_frame_nxt[i] = q_frame_r[i + 1];
            end
          end
          q_page_nxt[last_idx]  = q_page_r[0];
          q_ref_nxt[last_idx]   = 1'b0;
          q_age_nxt[last_idx]   = q_age_r[0];
          q_frame_nxt[last_idx] = q_frame_r[0];
        end else begin
          state_nxt = B_EVICT;
        end
      end

      B_SCAN: begin
        // oldest entry wins, ties go to the later one
        if (q_age_r[idx_r] >= best_age_r) begin
          best_nxt = idx_r;
          best_age_nxt = q_age_r[idx_r];
        end
        if (idx_r == last_idx) state_nxt = B_EVICT;
        else idx_nxt = idx_r + 1'b1;
      end

      B_EVICT: begin
        for (int i = 0; i < MAX_FRAMES - 1; i++) begin
          if (RC_W'(i + 1) < rc_r) begin
            if (IDX_W'(i) >= best_r) begin
              q_page_nxt[i]  = q_page_r[i + 1];
              q_ref_nxt[i]   = q_ref_r[i + 1];
              q_age_nxt[i]   = sat_inc(q_age_r[i + 1]);
              q_frame_nxt[i] = q_frame_r[i + 1];
            end else begin
              q_age_nxt[i] = sat_inc(q_age_r[i]);
            end
          end
        end
        q_page_nxt[last_idx]  = cmd_r.page;
        q_ref_nxt[last_idx]   = 1'b1;
        q_age_nxt[last_idx]   = '0;
        q_frame_nxt[last_idx] = q_frame_r[best_r];
        asc_nxt = sat_inc(asc_r);
        ov_nxt = 1'b1;  ol_nxt = 1'b1;  ost_nxt = ST_FAULT;
        opg_nxt = cmd_r.page;
        ofr_nxt = FRAME_W'(q_frame_r[best_r]);
        oof_nxt = cmd_r.offset & OFF_MASK;
        oev_nxt = 1'b1;
        oep_nxt = q_page_r[best_r];
        state_nxt = B_IDLE;
      end

      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      rc_r <= '0;  alloc_r <= '0;  disk_r <= '0;
      asc_r <= '0;  hits_r <= '0;  misses_r <= '0;
      policy_r <= POL_FIFO;
      clean_r <= RST_CLEAN;
      fc_r <= RST_FC;
      disk_lim_r <= RST_DISK;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rc_r <= rc_nxt;  alloc_r <= alloc_nxt;  disk_r <= disk_nxt;
      asc_r <= asc_nxt;  hits_r <= hits_nxt;  misses_r <= misses_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:      policy_r   <= cfg_wdata[POL_W-1:0];
          CFG_CLEAN:       clean_r    <= cfg_wdata;
          CFG_FRAME_COUNT: fc_r       <= cfg_wdata[FC_W-1:0];
          CFG_DISK_LIMIT:  disk_lim_r <= cfg_wdata[DISK_W-1:0];
        endcase
      end
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      q_page_r[i]  <= q_page_nxt[i];
      q_ref_r[i]   <= q_ref_nxt[i];
      q_age_r[i]   <= q_age_nxt[i];
      q_frame_r[i] <= q_frame_nxt[i];
    end
    cmd_r <= cmd_nxt;  left_r <= left_nxt;
    idx_r <= idx_nxt;  best_r <= best_nxt;  best_age_r <= best_age_nxt;
    ol_r <= ol_nxt;  ost_r <= ost_nxt;  opg_r <= opg_nxt;  ofr_r <= ofr_nxt;
    oof_r <= oof_nxt;  oev_r <= oev_nxt;  oep_r <= oep_nxt;
    oh_r <= hits_nxt;  om_r <= misses_nxt;
  end

  assign out_valid           = ov_r;
  assign out_status          = ost_r;
  assign out_page_number_res = opg_r;
  assign out_frame_index     = ofr_r;
  assign out_phys_offset     = oof_r;
  assign out_evicted_valid   = oev_r;
  assign out_evicted_page    = oep_r;
  assign out_hit_count       = oh_r;
  assign out_miss_count      = om_r;
  assign out_last            = ol_r;

endmodule

[src/prp_checker.sv]
// Port-level checks on the result stream of the tracker, bound to the top.
// Uses prp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module prp_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic       out_evicted_valid,
  input logic       out_last
);
  import prp_pkg::*;

  `PRP_ASSERT_IMP(a_status_code, out_valid, out_status <= ST_NO_SPACE)
  `PRP_ASSERT_IMP(a_evict_on_fault, out_valid && out_evicted_valid, out_status == ST_FAULT)
  `PRP_ASSERT_NXT(a_alloc_burst, out_valid && !out_last, out_valid)
  `PRP_ASSERT_IMP(a_access_single, out_valid && (out_status != ST_ALLOC_MEM) && (out_status != ST_ALLOC_DISK), out_last)

endmodule

bind page_replacement_policy prp_port_checks u_prp_checker (.*);
